// ===== src/b64se_pkg.sv =====
// Shared types, constants and the base64 alphabet function for the stream encoder.
`timescale 1ns / 1ps
package b64se_pkg;

  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam logic [7:0] PLUS_CHAR  = 8'h2B;
  localparam logic [7:0] SLASH_CHAR = 8'h2F;
  localparam logic [5:0] SEXTET_MASK = 6'h3F;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;

  typedef enum logic [1:0] {
    HAVE_ONE   = 2'd1,
    HAVE_TWO   = 2'd2,
    HAVE_THREE = 2'd3
  } have_t;

  typedef struct packed {
    logic [23:0] word;
    have_t       have;
    logic        mark;
  } group_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] c;
    c = 8'd0;
    case (v) inside
      [6'd0 : 6'd25]:  c = 8'h41 + {2'b00, v};
      [6'd26 : 6'd51]: c = 8'h61 + {2'b00, v} - 8'd26;
      [6'd52 : 6'd61]: c = 8'h30 + {2'b00, v} - 8'd52;
      6'd62:           c = PLUS_CHAR;
      default:         c = SLASH_CHAR;
    endcase
    return c;
  endfunction

endpackage

// ===== src/b64se_front.sv =====
// Front end: accepts bytes, gathers groups of up to three and hands them to the queue.
`timescale 1ns / 1ps
module b64se_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  logic [7:0]      data_byte,
  input  logic            end_of_message,
  output logic            q_push,
  output b64se_pkg::group_t q_entry,
  input  logic            q_full
);
  import b64se_pkg::*;

  logic [1:0]  count;
  logic [1:0]  count_next;
  logic [15:0] held;
  logic [15:0] held_next;
  logic        take;

  assign full = q_full;
  assign take = push && !q_full;

  always_comb begin
    count_next = count;
    held_next  = held;
    q_push     = 1'b0;
    q_entry    = '{word: 24'd0, have: HAVE_ONE, mark: 1'b1};
    case (count)
      2'd1: begin
        q_entry = '{word: {held[15:8], data_byte, 8'd0}, have: HAVE_TWO, mark: 1'b1};
        if (take) begin
          if (end_of_message) begin
            q_push     = 1'b1;
            count_next = 2'd0;
            held_next  = 16'd0;
          end else begin
            count_next = 2'd2;
            held_next  = {held[15:8], data_byte};
          end
        end
      end
      2'd2: begin
        q_entry = '{word: {held, data_byte}, have: HAVE_THREE, mark: end_of_message};
        if (take) begin
          q_push     = 1'b1;
          count_next = 2'd0;
          held_next  = 16'd0;
        end
      end
      default: begin
        q_entry = '{word: {data_byte, 16'd0}, have: HAVE_ONE, mark: 1'b1};
        if (take) begin
          if (end_of_message) begin
            q_push     = 1'b1;
            count_next = 2'd0;
            held_next  = 16'd0;
          end else begin
            count_next = 2'd1;
            held_next  = {data_byte, 8'd0};
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      held  <= 16'd0;
    end else begin
      count <= count_next;
      held  <= held_next;
    end
  end

endmodule

// ===== src/b64se_queue.sv =====
// Two-entry queue of gathered groups between the front and back ends.
`timescale 1ns / 1ps
module b64se_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  b64se_pkg::group_t wr_entry,
  output logic              q_full,
  input  logic              rd,
  output b64se_pkg::group_t rd_entry,
  output logic              q_empty
);
  import b64se_pkg::*;

  group_t                 mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   do_wr;
  logic                   do_rd;

  assign q_full   = count == QUEUE_CNT_W'(QUEUE_DEPTH);
  assign q_empty  = count == '0;
  assign do_wr    = wr && !q_full;
  assign do_rd    = rd && !q_empty;
  assign rd_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/b64se_back.sv =====
// Back end: turns each queued group into four characters, one per accepted item.
`timescale 1ns / 1ps
module b64se_back (
  input  logic              clk,
  input  logic              rst,
  input  b64se_pkg::group_t q_entry,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        out_char,
  output logic              last_char
);
  import b64se_pkg::*;

  group_t     cur;
  logic       busy;
  logic [1:0] idx;
  logic       done;
  logic [5:0] sextet;

  assign empty = !busy;
  assign done  = busy && pop && (idx == 2'd3);
  assign q_pop = !q_empty && (!busy || done);

  always_comb begin
    case (idx)
      2'd0:    sextet = cur.word[23:18] & SEXTET_MASK;
      2'd1:    sextet = cur.word[17:12] & SEXTET_MASK;
      2'd2:    sextet = cur.word[11:6] & SEXTET_MASK;
      default: sextet = cur.word[5:0] & SEXTET_MASK;
    endcase
    out_char  = sextet_char(sextet);
    last_char = 1'b0;
    if (idx == 2'd2 && cur.have == HAVE_ONE) begin
      out_char = PAD_CHAR;
    end
    if (idx == 2'd3) begin
      last_char = cur.mark;
      if (cur.have != HAVE_THREE) begin
        out_char = PAD_CHAR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else begin
      if (q_pop) begin
        busy <= 1'b1;
        idx  <= 2'd0;
      end else if (done) begin
        busy <= 1'b0;
        idx  <= 2'd0;
      end else if (busy && pop) begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule

// ===== src/base64_stream_encoder.sv =====
// Top level of the streaming base64 encoder with padding.
`timescale 1ns / 1ps
// Streaming base64 encoder with the standard alphabet and '=' padding. One raw byte is
// accepted per cycle while the two-entry group queue has room; every third byte, or a byte
// flagged as the end of a message, closes a group of four characters. The character side
// delivers one character per cycle while pop is held, and the single character port sets
// the pace of a steady stream. A character first appears once its group has been written
// into the queue and then loaded into the back end's current-group register. The final
// character of a message carries last_char.
module base64_stream_encoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic       end_of_message,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char,
  output logic       last_char
);
  import b64se_pkg::*;

  logic   q_push;
  logic   q_full;
  logic   q_pop;
  logic   q_empty;
  group_t wr_entry;
  group_t rd_entry;

  b64se_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .q_push         (q_push),
    .q_entry        (wr_entry),
    .q_full         (q_full)
  );

  b64se_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_push),
    .wr_entry (wr_entry),
    .q_full   (q_full),
    .rd       (q_pop),
    .rd_entry (rd_entry),
    .q_empty  (q_empty)
  );

  b64se_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_entry   (rd_entry),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .out_char  (out_char),
    .last_char (last_char)
  );

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the streaming base64 encoder with a character-level scoreboard.
`timescale 1ns / 1ps

import b64se_pkg::*;

typedef struct {
  logic [7:0] ch;
  logic       last;
} b64_char_t;

class char_scoreboard;
  logic [1:0]  byte_count;
  logic [15:0] held;
  b64_char_t   predicted_chars[$];
  int          errors;

  function new();
    byte_count = 2'd0;
    held = 16'd0;
    errors = 0;
  endfunction

  function logic [7:0] sextet_ascii(input logic [5:0] s);
    if (s < 6'd26) return 8'h41 + 8'(s);
    if (s < 6'd52) return 8'h61 + 8'(s - 6'd26);
    if (s < 6'd62) return 8'h30 + 8'(s - 6'd52);
    if (s == 6'd62) return PLUS_CHAR;
    return SLASH_CHAR;
  endfunction

  function void push_group(input logic [23:0] word, input int have, input logic mark);
    b64_char_t c;
    for (int i = 0; i < 4; i++) begin
      if (i >= have + 1) c.ch = PAD_CHAR;
      else c.ch = sextet_ascii(word[23 - 6 * i -: 6]);
      c.last = (i == 3) ? mark : 1'b0;
      predicted_chars.push_back(c);
    end
  endfunction

  function void note_byte(input logic [7:0] b, input logic eom);
    logic [1:0] cnt;
    cnt = (byte_count == 2'd3) ? 2'd0 : byte_count;
    if (cnt == 2'd0 && !eom) begin
      held = {b, 8'h00};
      byte_count = 2'd1;
      return;
    end
    if (cnt == 2'd1 && !eom) begin
      held = {held[15:8], b};
      byte_count = 2'd2;
      return;
    end
    if (cnt == 2'd0) push_group({b, 16'h0000}, 1, 1'b1);
    else if (cnt == 2'd1) push_group({held[15:8], b, 8'h00}, 2, 1'b1);
    else push_group({held, b}, 3, eom);
    byte_count = 2'd0;
    held = 16'd0;
  endfunction

  function void check_char(input logic [7:0] ch, input logic last);
    b64_char_t e;
    if (predicted_chars.size() == 0) begin
      $error("unexpected character: out_char %h last_char %b", ch, last);
      errors++;
      return;
    end
    e = predicted_chars.pop_front();
    if (ch !== e.ch) begin
      $error("out_char mismatch: expected %h, actual %h", e.ch, ch);
      errors++;
    end
    if (last !== e.last) begin
      $error("last_char mismatch: expected %b, actual %b", e.last, last);
      errors++;
    end
  endfunction

  function int waiting();
    return predicted_chars.size();
  endfunction
endclass

module testbench;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 90;
  localparam int DIRECTED_COUNT = 19;
  localparam logic [8:0] DIRECTED [DIRECTED_COUNT] = '{
    9'h100,
    9'h0FF, 9'h1FF,
    9'h0FF, 9'h0FF, 9'h1FF,
    9'h0FB, 9'h0EF, 9'h1BE,
    9'h000, 9'h000, 9'h000, 9'h100,
    9'h04D, 9'h061, 9'h06E, 9'h04D, 9'h161,
    9'h180
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] data_byte = 8'h00;
  logic       end_of_message = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_char;
  logic       last_char;

  bit             steady = 1'b0;
  int             quiet_cycles = 0;
  char_scoreboard sb = new();

  base64_stream_encoder i_dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .data_byte(data_byte),
    .end_of_message(end_of_message),
    .empty(empty),
    .pop(pop),
    .out_char(out_char),
    .last_char(last_char)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= steady || ($urandom_range(99) >= 38);
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) sb.check_char(out_char, last_char);
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eom);
    @(negedge clk);
    push <= 1'b1;
    data_byte <= b;
    end_of_message <= eom;
    do @(posedge clk); while (full);
    sb.note_byte(b, eom);
    if (!steady && $urandom_range(99) < 38) begin
      @(negedge clk);
      push <= 1'b0;
      while ($urandom_range(99) < 45) @(negedge clk);
    end
  endtask

  initial begin
    int sent;
    int len;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_COUNT; i++) send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      steady = (sent >= 40 && sent < 75);
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 10) : $urandom_range(9, 1);
      for (int i = 0; i < len; i++) begin
        send_byte(8'($urandom_range(255)), i == len - 1);
        sent++;
      end
    end
    steady = 1'b0;

    @(negedge clk);
    push <= 1'b0;
    while (sb.waiting() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (sb.errors == 0 && sb.waiting() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
